### rtl/core/efsm_pkg.sv
// Shared constants, codes and types of the encoder frame speed meter.
package efsm_pkg;

    // Encoder angle span and the quarter bands that mark a wrap.
    localparam int ANGLE_SPAN = 4096;
    localparam logic [15:0] SPAN_MOD  = 16'(ANGLE_SPAN);
    localparam logic [15:0] ANGLE_LO  = 16'(ANGLE_SPAN / 4);
    localparam logic [15:0] ANGLE_HI  = 16'((3 * ANGLE_SPAN) / 4);

    // Protocol constants.
    localparam logic [7:0] FUNC_READ   = 8'h03;
    localparam logic [9:0] MS_SCALE    = 10'd1000;
    localparam int         HDR_BYTES   = 5;
    localparam logic [8:0] FRAME_EXTRA = 9'(HDR_BYTES);
    localparam logic [7:0] POS_MAX     = 8'd255;

    // Input item kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_POLL = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // Result event codes.
    localparam logic EV_FRAME = 1'b0;
    localparam logic EV_POLL  = 1'b1;

    // Configuration register indexes.
    localparam int         CFG_IDX_W     = 1;
    localparam logic [0:0] CFG_STATION   = 1'b0;
    localparam logic [0:0] CFG_REG_COUNT = 1'b1;

    // Command queue between the front and back parts.
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_ADDR_W = $clog2(CMD_DEPTH);

    // Serial divider: scaled magnitude width and two quotient bits per step.
    localparam int PROD_W    = 26;
    localparam int DIV_STEPS = PROD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic        is_poll;
        logic        fail;
        logic [15:0] angle;
        logic [15:0] elapsed;
    } t_cmd;

    typedef struct packed {
        logic               event_res;
        logic [15:0]        angle;
        logic signed [15:0] delta;
        logic [15:0]        elapsed_ms;
        logic signed [15:0] speed;
        logic signed [15:0] turns;
        logic [15:0]        good_frames;
        logic [15:0]        failed_polls;
    } t_result;

endpackage

### rtl/core/efsm_if.sv
// Handshake channel interfaces for input items and result items.
interface efsm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface efsm_out_if;
    logic               valid;
    logic               ready;
    logic               event_res;
    logic [15:0]        angle;
    logic signed [15:0] delta;
    logic [15:0]        elapsed_ms;
    logic signed [15:0] speed;
    logic signed [15:0] turns;
    logic [15:0]        good_frames;
    logic [15:0]        failed_polls;

    modport source (output valid, output event_res, output angle, output delta,
                    output elapsed_ms, output speed, output turns,
                    output good_frames, output failed_polls, input ready);
    modport sink   (input valid, input event_res, input angle, input delta,
                    input elapsed_ms, input speed, input turns,
                    input good_frames, input failed_polls, output ready);
endinterface

### rtl/core/encoder_frame_speed_meter_unit.sv
// Top level of the encoder frame speed meter.
//
// The block watches the link to an encoder station. Items arrive on i_item with
// a kind: a received reply byte, a note that a poll was sent, or a one
// millisecond tick. Reply bytes build a read-register response frame of
// 2*register_count+5 bytes; a complete frame whose station, function code and
// byte count match yields a new angle, its wrap-corrected change, the turn
// counter and a speed in counts per second (a frame with zero elapsed time
// repeats the last speed). Each poll yields an acknowledge item that carries
// the failure count. Results leave on o_result. Registers are written through
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so only while idle, which the
// block itself does not enforce. The front end takes one item per cycle as long
// as its four-entry command queue has room; ticks and plain bytes never enter
// the queue. The back end handles one command at a time: a poll or a frame with
// zero elapsed time goes straight to the emit state; any other frame passes the
// multiply state, the 13-step radix-4 speed divider and the saturate state.
// When the receiver stalls, the result register holds its item, the back end
// waits with its next result, and the queue fills before i_item.ready drops.
// Synchronous reset clears the measurement counters, the queue, the frame
// position and the registers to station 1 and one register per reply.
module encoder_frame_speed_meter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [efsm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    efsm_in_if.sink                       i_item,
    efsm_out_if.source                    o_result
);

    logic              w_push;
    logic              w_full;
    logic              w_cmd_valid;
    logic              w_pop;
    efsm_pkg::t_cmd    w_cmd_in;
    efsm_pkg::t_cmd    w_cmd_out;
    efsm_pkg::t_result w_res;
    logic              w_res_valid;

    // Frame assembly and item classification.
    efsm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    // The queue lets the front keep taking bytes while a speed is computed.
    efsm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd_out),
        .i_pop   (w_pop)
    );

    // Measurement and result register.
    efsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_result.ready)
    );

    assign o_result.valid        = w_res_valid;
    assign o_result.event_res    = w_res.event_res;
    assign o_result.angle        = w_res.angle;
    assign o_result.delta        = w_res.delta;
    assign o_result.elapsed_ms   = w_res.elapsed_ms;
    assign o_result.speed        = w_res.speed;
    assign o_result.turns        = w_res.turns;
    assign o_result.good_frames  = w_res.good_frames;
    assign o_result.failed_polls = w_res.failed_polls;

endmodule

### rtl/core/efsm_cmd_fifo.sv
// Short command queue between the frame front end and the measurement back end.
module efsm_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  efsm_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output efsm_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);

    efsm_pkg::t_cmd r_mem [efsm_pkg::CMD_DEPTH];
    logic [efsm_pkg::CMD_ADDR_W:0] r_wr_ptr;
    logic [efsm_pkg::CMD_ADDR_W:0] r_rd_ptr;

    assign o_valid = (r_wr_ptr != r_rd_ptr);
    assign o_full  = (r_wr_ptr[efsm_pkg::CMD_ADDR_W-1:0] == r_rd_ptr[efsm_pkg::CMD_ADDR_W-1:0])
                     && (r_wr_ptr[efsm_pkg::CMD_ADDR_W] != r_rd_ptr[efsm_pkg::CMD_ADDR_W]);
    assign o_cmd   = r_mem[r_rd_ptr[efsm_pkg::CMD_ADDR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[efsm_pkg::CMD_ADDR_W-1:0]] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

### rtl/core/efsm_front.sv
// Front end: takes items, assembles reply frames, counts ticks and queues commands.
module efsm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [efsm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    efsm_in_if.sink                       i_item,
    input  logic                          i_q_full,
    output logic                          o_push,
    output efsm_pkg::t_cmd                o_cmd
);

    logic [7:0]  r_station;
    logic [6:0]  r_reg_count;
    logic [7:0]  r_pos;
    logic        r_pending;
    logic [15:0] r_ms;
    logic [7:0]  r_hdr [efsm_pkg::HDR_BYTES];

    logic        w_take;
    logic        w_is_byte;
    logic        w_is_poll;
    logic        w_is_tick;
    logic [7:0]  n_pos;
    logic [7:0]  w_hdr [efsm_pkg::HDR_BYTES];
    logic [8:0]  w_frame_len;
    logic        w_frame_ok;

    assign i_item.ready = !i_q_full;
    assign w_take    = i_item.valid && !i_q_full;
    assign w_is_byte = w_take && (i_item.kind == efsm_pkg::KIND_BYTE);
    assign w_is_poll = w_take && (i_item.kind == efsm_pkg::KIND_POLL);
    assign w_is_tick = w_take && (i_item.kind == efsm_pkg::KIND_TICK);

    // Header as it stands once the current byte has been stored.
    always_comb begin
        for (int k = 0; k < efsm_pkg::HDR_BYTES; k++) begin
            w_hdr[k] = (r_pos == 8'(k)) ? i_item.data_byte : r_hdr[k];
        end
    end

    assign n_pos       = (r_pos < efsm_pkg::POS_MAX) ? r_pos + 8'd1 : r_pos;
    assign w_frame_len = {1'b0, r_reg_count, 1'b0} + efsm_pkg::FRAME_EXTRA;
    assign w_frame_ok  = w_is_byte
                         && ({1'b0, n_pos} >= w_frame_len)
                         && (w_hdr[0] == r_station)
                         && (w_hdr[1] == efsm_pkg::FUNC_READ)
                         && (w_hdr[2] == {r_reg_count, 1'b0});

    assign o_push          = w_frame_ok || w_is_poll;
    assign o_cmd.is_poll   = w_is_poll;
    assign o_cmd.fail      = r_pending;
    assign o_cmd.angle     = {w_hdr[3], w_hdr[4]};
    assign o_cmd.elapsed   = r_ms;

    always_ff @(posedge i_clk) begin
        if (w_is_byte && (r_pos < 8'(efsm_pkg::HDR_BYTES))) begin
            r_hdr[r_pos[2:0]] <= i_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station   <= 8'd1;
            r_reg_count <= 7'd1;
            r_pos       <= '0;
            r_pending   <= 1'b0;
            r_ms        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    efsm_pkg::CFG_STATION:   r_station   <= i_cfg_data;
                    efsm_pkg::CFG_REG_COUNT: r_reg_count <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (w_is_tick) begin
                r_ms <= r_ms + 16'd1;
            end
            if (w_is_poll) begin
                r_pos     <= '0;
                r_pending <= 1'b1;
            end
            if (w_is_byte) begin
                if (w_frame_ok) begin
                    r_pos     <= '0;
                    r_pending <= 1'b0;
                    r_ms      <= '0;
                end else begin
                    r_pos <= n_pos;
                end
            end
        end
    end

endmodule

### rtl/core/efsm_back.sv
// Back end: angle unwrap, turn and frame counters, serial speed divider, result register.
module efsm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  efsm_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output efsm_pkg::t_result o_res,
    output logic              o_res_valid,
    input  logic              i_res_ready
);

    typedef enum logic [2:0] {S_IDLE, S_MULT, S_DIV, S_SAT, S_EMIT} t_state;

    t_state                         r_state;
    logic [15:0]                    r_prev_angle;
    logic signed [15:0]             r_held_speed;
    logic signed [15:0]             r_turns;
    logic [15:0]                    r_good;
    logic [15:0]                    r_failed;
    logic                           r_event;
    logic signed [15:0]             r_delta;
    logic [15:0]                    r_elapsed;
    logic [15:0]                    r_mag;
    logic                           r_neg;
    logic [efsm_pkg::PROD_W-1:0]    r_num;
    logic [15:0]                    r_rem;
    logic [efsm_pkg::DIV_CNT_W-1:0] r_cnt;
    efsm_pkg::t_result              r_out;
    logic                           r_out_valid;

    logic                           w_wrap_up;
    logic                           w_wrap_dn;
    logic [15:0]                    n_delta;
    logic [15:0]                    w_abs;
    logic [efsm_pkg::PROD_W-1:0]    n_num;
    logic [15:0]                    n_rem;
    logic [16:0]                    w_trial [2];
    logic [efsm_pkg::PROD_W-1:0]    w_num_mid;
    logic [15:0]                    w_rem_mid;
    logic signed [15:0]             n_speed;
    logic                           w_emit;

    assign o_pop       = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    // The result register loads when it is empty or being handed over.
    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || i_res_ready);

    // Wrap correction across the low and high quarter bands.
    assign w_wrap_up = (i_cmd.angle < efsm_pkg::ANGLE_LO) && (r_prev_angle > efsm_pkg::ANGLE_HI);
    assign w_wrap_dn = (i_cmd.angle > efsm_pkg::ANGLE_HI) && (r_prev_angle < efsm_pkg::ANGLE_LO);
    always_comb begin
        n_delta = i_cmd.angle - r_prev_angle;
        if (w_wrap_up) begin
            n_delta = n_delta + efsm_pkg::SPAN_MOD;
        end else if (w_wrap_dn) begin
            n_delta = n_delta - efsm_pkg::SPAN_MOD;
        end
    end
    assign w_abs = n_delta[15] ? (~n_delta + 16'd1) : n_delta;

    // Two restoring division steps per cycle; quotient bits shift in at the bottom.
    always_comb begin
        w_trial[0] = {r_rem, r_num[efsm_pkg::PROD_W-1]};
        w_num_mid  = {r_num[efsm_pkg::PROD_W-2:0], 1'b0};
        if (w_trial[0] >= {1'b0, r_elapsed}) begin
            w_rem_mid    = 16'(w_trial[0] - {1'b0, r_elapsed});
            w_num_mid[0] = 1'b1;
        end else begin
            w_rem_mid = w_trial[0][15:0];
        end
        w_trial[1] = {w_rem_mid, w_num_mid[efsm_pkg::PROD_W-1]};
        n_num      = {w_num_mid[efsm_pkg::PROD_W-2:0], 1'b0};
        if (w_trial[1] >= {1'b0, r_elapsed}) begin
            n_rem    = 16'(w_trial[1] - {1'b0, r_elapsed});
            n_num[0] = 1'b1;
        end else begin
            n_rem = w_trial[1][15:0];
        end
    end

    // Apply the sign and saturate the quotient to 16 bits.
    always_comb begin
        if (r_neg) begin
            if (r_num > efsm_pkg::PROD_W'(32768)) begin
                n_speed = 16'sh8000;
            end else begin
                n_speed = -$signed(r_num[15:0]);
            end
        end else begin
            if (r_num > efsm_pkg::PROD_W'(32767)) begin
                n_speed = 16'sh7FFF;
            end else begin
                n_speed = $signed(r_num[15:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_angle <= '0;
            r_held_speed <= '0;
            r_turns      <= '0;
            r_good       <= '0;
            r_failed     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.is_poll) begin
                            r_failed  <= r_failed + 16'(i_cmd.fail);
                            r_event   <= efsm_pkg::EV_POLL;
                            r_delta   <= '0;
                            r_elapsed <= '0;
                            r_state   <= S_EMIT;
                        end else begin
                            r_prev_angle <= i_cmd.angle;
                            r_good       <= r_good + 16'd1;
                            if (w_wrap_up) begin
                                r_turns <= r_turns + 16'sd1;
                            end else if (w_wrap_dn) begin
                                r_turns <= r_turns - 16'sd1;
                            end
                            r_event   <= efsm_pkg::EV_FRAME;
                            r_delta   <= $signed(n_delta);
                            r_elapsed <= i_cmd.elapsed;
                            r_mag     <= w_abs;
                            r_neg     <= n_delta[15];
                            r_state   <= (i_cmd.elapsed == 16'd0) ? S_EMIT : S_MULT;
                        end
                    end
                end
                S_MULT: begin
                    r_num   <= efsm_pkg::PROD_W'(r_mag * efsm_pkg::MS_SCALE);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num <= n_num;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == efsm_pkg::DIV_CNT_W'(efsm_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_held_speed <= n_speed;
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out.event_res    <= r_event;
                        r_out.angle        <= r_prev_angle;
                        r_out.delta        <= r_delta;
                        r_out.elapsed_ms   <= r_elapsed;
                        r_out.speed        <= r_held_speed;
                        r_out.turns        <= r_turns;
                        r_out.good_frames  <= r_good;
                        r_out.failed_polls <= r_failed;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/efsm_checker.sv
// Port-level checks of the encoder frame speed meter, bound to the top level.
module efsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_event,
    input logic [15:0] i_out_delta,
    input logic [15:0] i_out_elapsed,
    input logic [15:0] i_out_good,
    input logic [15:0] i_out_failed
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_delta)
            && $stable(i_out_good) && $stable(i_out_failed))
        else $error("result changed while stalled");

    // A poll acknowledge carries no angle change and no elapsed time.
    a_poll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_event == efsm_pkg::EV_POLL)
            |-> (i_out_delta == 16'd0) && (i_out_elapsed == 16'd0))
        else $error("poll acknowledge with nonzero delta or elapsed time");

    // Reset empties the result register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // The first cycle out of reset shows no result.
    a_first_counts: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |-> !i_out_valid)
        else $error("result valid in the first cycle out of reset");

endmodule

bind encoder_frame_speed_meter_unit efsm_checker u_efsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_event   (o_result.event_res),
    .i_out_delta   (o_result.delta),
    .i_out_elapsed (o_result.elapsed_ms),
    .i_out_good    (o_result.good_frames),
    .i_out_failed  (o_result.failed_polls)
);
